[rtl/itee_pkg.sv]
package itee_pkg;

	// token kinds carried on s_tuser
	localparam logic [2:0] ACT_NUM   = 3'd0;
	localparam logic [2:0] ACT_PLUS  = 3'd1;
	localparam logic [2:0] ACT_MINUS = 3'd2;
	localparam logic [2:0] ACT_TIMES = 3'd3;
	localparam logic [2:0] ACT_DIV   = 3'd4;
	localparam logic [2:0] ACT_MOD   = 3'd5;

	// result status carried on m_tuser
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_SYNTAX = 3'd2;
	localparam logic [2:0] ST_TRAIL  = 3'd3;
	localparam logic [2:0] ST_DIV0   = 3'd4;
	localparam logic [2:0] ST_MOD0   = 3'd5;

	// pending term operator; the unused code acts as multiply
	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_DIV = 2'd1;
	localparam logic [1:0] OP_MOD = 2'd2;

	localparam int ACT_BITS    = 3;
	localparam int STATUS_BITS = 3;
	localparam int ANS_MAX     = 32;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_WRITE
	} ctl_state_t;

	typedef enum logic [1:0] {
		A_IDLE,
		A_RUN,
		A_FIX
	} alu_state_t;

	// what the write step does with the running state
	typedef enum logic [2:0] {
		PL_CLEAR,
		PL_NUM,
		PL_DONE,
		PL_ADD,
		PL_MULT
	} plan_t;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

endpackage

[rtl/itee_alu.sv]
// Shared iterative unit: shift-add multiply and restoring divide on one adder.
module itee_alu #(
	parameter int W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  itee_pkg::alu_ctl_t ctl,
	input  logic [W-1:0]       a,
	input  logic [W-1:0]       b,
	output itee_pkg::alu_sts_t sts,
	output logic [W-1:0]       result
);

	localparam int CNT_W = $clog2(W);

	itee_pkg::alu_state_t state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [1:0]           op_q;
	logic                 neg_q;
	logic                 done_q;
	logic [W-1:0]         acc_q;
	logic [W-1:0]         opa_q;
	logic [W-1:0]         opb_q;
	logic [W-1:0]         result_q;

	logic                 is_div_op;
	logic [W-1:0]         mag_a;
	logic [W-1:0]         mag_b;
	logic [W-1:0]         rem_sh;
	logic [W-1:0]         fix_sel;
	logic [W-1:0]         add_x;
	logic [W-1:0]         add_y;
	logic                 add_cin;
	logic [W:0]           add_sum;

	assign is_div_op = (op_q == itee_pkg::OP_DIV) || (op_q == itee_pkg::OP_MOD);
	assign mag_a     = a[W-1] ? (~a + {{(W-1){1'b0}}, 1'b1}) : a;
	assign mag_b     = b[W-1] ? (~b + {{(W-1){1'b0}}, 1'b1}) : b;
	assign rem_sh    = {acc_q[W-2:0], opa_q[W-1]};
	assign fix_sel   = (op_q == itee_pkg::OP_DIV) ? opa_q : acc_q;

	// route operands to the single adder
	always_comb begin
		add_x   = acc_q;
		add_y   = '0;
		add_cin = 1'b0;
		unique case (state_q)
			itee_pkg::A_RUN: begin
				if (is_div_op) begin
					add_x   = rem_sh;
					add_y   = ~opb_q;
					add_cin = 1'b1;
				end else begin
					add_x = acc_q;
					add_y = opb_q[0] ? opa_q : '0;
				end
			end
			itee_pkg::A_FIX: begin
				add_x   = '0;
				add_y   = neg_q ? ~fix_sel : fix_sel;
				add_cin = neg_q;
			end
			default: begin
				add_x = acc_q;
			end
		endcase
	end

	assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_cin};

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itee_pkg::A_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				itee_pkg::A_IDLE: begin
					if (ctl.start) begin
						state_q <= itee_pkg::A_RUN;
						cnt_q   <= CNT_W'(W - 1);
					end
				end
				itee_pkg::A_RUN: begin
					cnt_q <= cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
					if (cnt_q == '0) begin
						state_q <= itee_pkg::A_FIX;
					end
				end
				itee_pkg::A_FIX: begin
					state_q <= itee_pkg::A_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= itee_pkg::A_IDLE;
				end
			endcase
		end
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (state_q == itee_pkg::A_IDLE && ctl.start) begin
			op_q  <= ctl.op;
			acc_q <= '0;
			if ((ctl.op == itee_pkg::OP_DIV) || (ctl.op == itee_pkg::OP_MOD)) begin
				opa_q <= mag_a;
				opb_q <= mag_b;
				neg_q <= (ctl.op == itee_pkg::OP_DIV) ? (a[W-1] ^ b[W-1]) : a[W-1];
			end else begin
				opa_q <= a;
				opb_q <= b;
				neg_q <= 1'b0;
			end
		end else if (state_q == itee_pkg::A_RUN) begin
			if (is_div_op) begin
				// keep difference when no borrow, shift quotient bit in
				acc_q <= add_sum[W] ? add_sum[W-1:0] : rem_sh;
				opa_q <= {opa_q[W-2:0], add_sum[W]};
			end else begin
				acc_q <= add_sum[W-1:0];
				opa_q <= {opa_q[W-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[W-1:1]};
			end
		end else if (state_q == itee_pkg::A_FIX) begin
			result_q <= add_sum[W-1:0];
		end
	end

	assign sts.busy = (state_q != itee_pkg::A_IDLE);
	assign sts.done = done_q;
	assign result   = result_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == itee_pkg::A_IDLE)
		else $error("unit started while busy");

	a_run_to_fix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itee_pkg::A_RUN && cnt_q == '0) |=> state_q == itee_pkg::A_FIX)
		else $error("iteration count overran");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held longer than one cycle");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itee_pkg::A_RUN && is_div_op) |-> acc_q < opb_q)
		else $error("partial remainder reached divisor");

endmodule

[rtl/infix_token_expression_evaluator_top.sv]
// channel  dir  tdata                 tuser           tlast
// s_*      in   token_value           action          last_token
// m_*      out  answer (low 32 bits)  status          -
//
// A number token that is not the last one skips the unit and goes straight to its write step.
// A number with last set, or a well-formed operator, runs the shared
// multiply/divide unit for DATA_BITS iterations before its write step.
// Error tokens and trailing operators also skip the unit and go straight to the write step.
// arst_n clears the running expression state and empties the output register.
// A new word is accepted while a result waits on m_*; that word stalls only
// at its write step until the output register frees.
module infix_token_expression_evaluator_top #(
	parameter int DATA_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [DATA_BITS-1:0] token_value
	input  logic [((DATA_BITS+7)/8)*8-1:0]        s_tdata,
	// [2:0] action
	input  logic [itee_pkg::ACT_BITS-1:0]         s_tuser,
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [ANS_BITS-1:0] answer, rest zero
	output logic [((DATA_BITS+7)/8)*8-1:0]        m_tdata,
	// [2:0] status
	output logic [itee_pkg::STATUS_BITS-1:0]      m_tuser
);

	localparam int TDW      = ((DATA_BITS + 7) / 8) * 8;
	localparam int ANS_BITS = (DATA_BITS < itee_pkg::ANS_MAX) ? DATA_BITS : itee_pkg::ANS_MAX;

	itee_pkg::ctl_state_t state_q;
	itee_pkg::ctl_state_t state_d;
	itee_pkg::plan_t      plan_q;
	itee_pkg::plan_t      plan_d;
	logic [2:0]           status_q;
	logic [2:0]           status_d;
	logic [2:0]           act_q;
	logic [DATA_BITS-1:0] val_q;

	// running expression state
	logic [DATA_BITS-1:0] sum_q;
	logic                 sum_neg_q;
	logic [DATA_BITS-1:0] term_q;
	logic [1:0]           term_op_q;
	logic [DATA_BITS-1:0] held_q;
	logic                 prev_op_q;

	logic                 out_vld_q;
	logic [2:0]           out_status_q;
	logic [ANS_BITS-1:0]  out_ans_q;

	logic                 accept;
	logic                 write_en;
	logic [2:0]           act;
	logic [DATA_BITS-1:0] val;
	logic                 is_num;
	logic                 is_op;
	logic                 term_is_div;
	logic                 zero_div;
	logic [2:0]           div0_status;
	logic [DATA_BITS-1:0] total;

	itee_pkg::alu_ctl_t   alu_ctl;
	itee_pkg::alu_sts_t   alu_sts;
	logic [DATA_BITS-1:0] alu_res;

	assign act    = s_tuser;
	assign val    = s_tdata[DATA_BITS-1:0];
	assign accept = s_tvalid && s_tready;
	assign is_num = (act == itee_pkg::ACT_NUM);
	assign is_op  = (act == itee_pkg::ACT_PLUS) || (act == itee_pkg::ACT_MINUS) ||
	                (act == itee_pkg::ACT_TIMES) || (act == itee_pkg::ACT_DIV) ||
	                (act == itee_pkg::ACT_MOD);

	// divisor check for the pending term
	assign term_is_div = (term_op_q == itee_pkg::OP_DIV) || (term_op_q == itee_pkg::OP_MOD);
	assign zero_div    = term_is_div && ((is_num ? val : held_q) == '0);
	assign div0_status = (term_op_q == itee_pkg::OP_DIV) ? itee_pkg::ST_DIV0 : itee_pkg::ST_MOD0;

	assign write_en = (state_q == itee_pkg::S_WRITE) && (!out_vld_q || m_tready);
	assign total    = sum_neg_q ? (sum_q - alu_res) : (sum_q + alu_res);

	// sequencer: decode token, run unit, write result
	always_comb begin
		state_d      = state_q;
		plan_d       = plan_q;
		status_d     = status_q;
		alu_ctl.start = 1'b0;
		alu_ctl.op    = term_is_div ? term_op_q : itee_pkg::OP_MUL;
		s_tready     = 1'b0;
		unique case (state_q)
			itee_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d  = itee_pkg::S_WRITE;
					plan_d   = itee_pkg::PL_CLEAR;
					status_d = itee_pkg::ST_SYNTAX;
					if (is_num) begin
						if (!prev_op_q) begin
							status_d = itee_pkg::ST_SYNTAX;
						end else if (!s_tlast) begin
							plan_d   = itee_pkg::PL_NUM;
							status_d = itee_pkg::ST_OK;
						end else if (zero_div) begin
							status_d = div0_status;
						end else begin
							plan_d        = itee_pkg::PL_DONE;
							status_d      = itee_pkg::ST_DONE;
							alu_ctl.start = 1'b1;
							state_d       = itee_pkg::S_CALC;
						end
					end else if (is_op) begin
						if (zero_div) begin
							status_d = div0_status;
						end else if (prev_op_q) begin
							status_d = itee_pkg::ST_SYNTAX;
						end else if (s_tlast) begin
							status_d = itee_pkg::ST_TRAIL;
						end else begin
							plan_d = ((act == itee_pkg::ACT_PLUS) || (act == itee_pkg::ACT_MINUS)) ?
							         itee_pkg::PL_ADD : itee_pkg::PL_MULT;
							status_d      = itee_pkg::ST_OK;
							alu_ctl.start = 1'b1;
							state_d       = itee_pkg::S_CALC;
						end
					end
				end
			end
			itee_pkg::S_CALC: begin
				if (alu_sts.done) begin
					state_d = itee_pkg::S_WRITE;
				end
			end
			itee_pkg::S_WRITE: begin
				if (write_en) begin
					state_d = itee_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = itee_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itee_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the decoded word
	always_ff @(posedge clk) begin
		plan_q   <= plan_d;
		status_q <= status_d;
		if (accept) begin
			act_q <= act;
			val_q <= val;
		end
	end

	// update expression state at the write step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			sum_neg_q <= 1'b0;
			term_q    <= {{(DATA_BITS-1){1'b0}}, 1'b1};
			term_op_q <= itee_pkg::OP_MUL;
			held_q    <= '0;
			prev_op_q <= 1'b1;
		end else if (write_en) begin
			unique case (plan_q)
				itee_pkg::PL_NUM: begin
					held_q    <= val_q;
					prev_op_q <= 1'b0;
				end
				itee_pkg::PL_ADD: begin
					sum_q     <= total;
					sum_neg_q <= (act_q == itee_pkg::ACT_MINUS);
					term_q    <= {{(DATA_BITS-1){1'b0}}, 1'b1};
					term_op_q <= itee_pkg::OP_MUL;
					prev_op_q <= 1'b1;
				end
				itee_pkg::PL_MULT: begin
					term_q    <= alu_res;
					term_op_q <= (act_q == itee_pkg::ACT_TIMES) ? itee_pkg::OP_MUL :
					             (act_q == itee_pkg::ACT_DIV) ? itee_pkg::OP_DIV : itee_pkg::OP_MOD;
					prev_op_q <= 1'b1;
				end
				default: begin
					// completion and every error drop the expression
					sum_q     <= '0;
					sum_neg_q <= 1'b0;
					term_q    <= {{(DATA_BITS-1){1'b0}}, 1'b1};
					term_op_q <= itee_pkg::OP_MUL;
					held_q    <= '0;
					prev_op_q <= 1'b1;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (write_en) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			out_status_q <= status_q;
			out_ans_q    <= (plan_q == itee_pkg::PL_DONE) ? total[ANS_BITS-1:0] : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = TDW'(out_ans_q);

	itee_alu #(
		.W(DATA_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (term_q),
		.b      (is_num ? val : held_q),
		.sts    (alu_sts),
		.result (alu_res)
	);

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != itee_pkg::S_IDLE)
		else $error("accepted word did not start a step");

	a_calc_has_unit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itee_pkg::S_CALC |-> alu_sts.busy || alu_sts.done)
		else $error("waiting on an idle unit");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |=> out_vld_q && $stable(out_status_q) && $stable(out_ans_q))
		else $error("pending result overwritten");

endmodule

[bench/tb_top.sv]
import itee_pkg::*;

// Tracks the running expression and queues the result word each token should produce
class token_scoreboard;
	typedef struct {
		logic [STATUS_BITS-1:0] status;
		logic [31:0]            answer;
	} outcome_t;

	outcome_t    awaited[$];
	int          errors;

	// running expression: additive sum, pending sign, multiplicative term
	logic [31:0] sum_acc;
	logic        sub_term;
	logic [31:0] term_acc;
	logic [1:0]  term_op;
	logic [31:0] held_num;
	logic        after_op;

	function new();
		errors = 0;
		clear_expr();
	endfunction

	function void clear_expr();
		sum_acc  = '0;
		sub_term = 1'b0;
		term_acc = 32'd1;
		term_op  = OP_MUL;
		held_num = '0;
		after_op = 1'b1;
	endfunction

	// apply the pending term operator; division truncates toward zero
	function logic [STATUS_BITS-1:0] eval_term(logic [31:0] a, logic [31:0] b,
			logic [1:0] op, output logic [31:0] res);
		logic [31:0] ua;
		logic [31:0] ub;
		logic [31:0] q;
		res = '0;
		if (op == OP_DIV || op == OP_MOD) begin
			if (b == '0)
				return (op == OP_DIV) ? ST_DIV0 : ST_MOD0;
			ua = a[31] ? -a : a;
			ub = b[31] ? -b : b;
			if (op == OP_DIV) begin
				q   = ua / ub;
				res = (a[31] != b[31]) ? -q : q;
			end else begin
				q   = ua % ub;
				res = a[31] ? -q : q;
			end
		end else begin
			res = a * b;
		end
		return ST_OK;
	endfunction

	// queue one result word; errors drop the expression
	function void post(logic [STATUS_BITS-1:0] status, logic [31:0] total);
		outcome_t o;
		if (status != ST_OK && status != ST_DONE)
			clear_expr();
		o.status = status;
		o.answer = (status == ST_DONE) ? total : '0;
		awaited.push_back(o);
	endfunction

	function void note_token(logic [ACT_BITS-1:0] kind, logic [31:0] value, logic is_last);
		logic [31:0]            t;
		logic [31:0]            total;
		logic [STATUS_BITS-1:0] st;
		if (kind > ACT_MOD) begin
			post(ST_SYNTAX, '0);
		end else if (kind == ACT_NUM) begin
			if (!after_op) begin
				post(ST_SYNTAX, '0);
			end else begin
				held_num = value;
				after_op = 1'b0;
				if (!is_last) begin
					post(ST_OK, '0);
				end else begin
					st = eval_term(term_acc, held_num, term_op, t);
					if (st != ST_OK) begin
						post(st, '0);
					end else begin
						total = sub_term ? sum_acc - t : sum_acc + t;
						clear_expr();
						post(ST_DONE, total);
					end
				end
			end
		end else begin
			// operator: zero divisor wins over bad syntax
			st = eval_term(term_acc, held_num, term_op, t);
			if (st != ST_OK) begin
				post(st, '0);
			end else if (after_op) begin
				post(ST_SYNTAX, '0);
			end else begin
				if (kind == ACT_PLUS || kind == ACT_MINUS) begin
					sum_acc  = sub_term ? sum_acc - t : sum_acc + t;
					sub_term = (kind == ACT_MINUS);
					term_acc = 32'd1;
					term_op  = OP_MUL;
				end else begin
					term_acc = t;
					term_op  = (kind == ACT_TIMES) ? OP_MUL :
						(kind == ACT_DIV) ? OP_DIV : OP_MOD;
				end
				after_op = 1'b1;
				post(is_last ? ST_TRAIL : ST_OK, '0);
			end
		end
	endfunction

	function void check_result(logic [STATUS_BITS-1:0] status, logic [31:0] answer);
		outcome_t o;
		if (awaited.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result word: status %0d answer %0d",
					status, $signed(answer));
			return;
		end
		o = awaited.pop_front();
		if (o.status !== status || o.answer !== answer) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected status %0d answer %0d, got status %0d answer %0d",
					o.status, $signed(o.answer), status, $signed(answer));
		end
	endfunction
endclass

module tb_top;
	localparam int WORD_BITS  = 32;
	localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;
	// action codes the block does not define
	localparam logic [ACT_BITS-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ACT_BITS-1:0] ACT_SPARE_HI = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_BITS-1:0]  s_tdata;
	logic [ACT_BITS-1:0]    s_tuser;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_BITS-1:0]  m_tdata;
	logic [STATUS_BITS-1:0] m_tuser;

	int src_idle_pct  = 34;
	int sink_idle_pct = 66;
	int tokens_sent   = 0;

	token_scoreboard tracker = new;

	infix_token_expression_evaluator_top #(
		.DATA_BITS(WORD_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// give up on a hung run
	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	// stall the result side at random
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// compare every accepted result word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tuser, m_tdata[31:0]);
	end

	// offer one token, idling first at random, and hold it until accepted
	task automatic send_token(logic [ACT_BITS-1:0] kind, logic [31:0] value, logic is_last);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= value;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		tracker.note_token(kind, value, is_last);
		tokens_sent++;
	endtask

	// operands lean toward zero, extremes and small values
	function automatic logic [31:0] pick_operand();
		logic [31:0] corner_vals[4];
		corner_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd1};
		case ($urandom_range(0, 7))
			0: return '0;
			1: return corner_vals[$urandom_range(0, 3)];
			2, 3: return $urandom_range(0, 40) - 20;
			default: return $urandom;
		endcase
	endfunction

	// well-formed expression with random operands and operators
	task automatic send_expression();
		int n;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) begin
			send_token(ACT_NUM, pick_operand(), i == n - 1);
			if (i < n - 1)
				send_token(ACT_BITS'($urandom_range(ACT_PLUS, ACT_MOD)), $urandom, 1'b0);
		end
	endtask

	// random tokens of any kind, closed by a spare code so the next expression starts clean
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n)
			send_token(ACT_BITS'($urandom_range(ACT_NUM, ACT_SPARE_HI)), $urandom,
				$urandom_range(0, 2) == 0);
		send_token(ACT_BITS'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), $urandom,
			1'($urandom));
	endtask

	task automatic send_mix(int upto);
		while (tokens_sent < upto) begin
			if ($urandom_range(0, 99) < 80)
				send_expression();
			else
				send_noise();
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_NUM;
		s_tlast  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// leading operator, then a number after a number
		send_token(ACT_PLUS, $urandom, 1'b0);
		send_token(ACT_NUM, 32'd1, 1'b0);
		send_token(ACT_NUM, 32'd2, 1'b0);
		// max * 2 - min wraps around
		send_token(ACT_NUM, 32'h7fff_ffff, 1'b0);
		send_token(ACT_TIMES, $urandom, 1'b0);
		send_token(ACT_NUM, 32'd2, 1'b0);
		send_token(ACT_MINUS, $urandom, 1'b0);
		send_token(ACT_NUM, 32'h8000_0000, 1'b1);
		// most negative over minus one, then that modulo minus one
		send_token(ACT_NUM, 32'h8000_0000, 1'b0);
		send_token(ACT_DIV, $urandom, 1'b0);
		send_token(ACT_NUM, 32'hffff_ffff, 1'b0);
		send_token(ACT_MOD, $urandom, 1'b0);
		send_token(ACT_NUM, 32'hffff_ffff, 1'b1);
		// zero divisor caught at the final number
		send_token(ACT_NUM, 32'd5, 1'b0);
		send_token(ACT_DIV, $urandom, 1'b0);
		send_token(ACT_NUM, 32'd0, 1'b1);
		// zero modulus caught at the next operator
		send_token(ACT_NUM, 32'hffff_fffd, 1'b0);
		send_token(ACT_MOD, $urandom, 1'b0);
		send_token(ACT_NUM, 32'd0, 1'b0);
		send_token(ACT_TIMES, $urandom, 1'b0);
		// operator after operator, trailing operator, spare codes
		send_token(ACT_NUM, 32'd1, 1'b0);
		send_token(ACT_PLUS, $urandom, 1'b0);
		send_token(ACT_MINUS, $urandom, 1'b0);
		send_token(ACT_NUM, 32'd4, 1'b0);
		send_token(ACT_DIV, $urandom, 1'b1);
		send_token(ACT_SPARE_LO, $urandom, 1'b0);
		send_token(ACT_SPARE_HI, $urandom, 1'b1);

		// random traffic under three idle patterns
		send_mix(240);
		src_idle_pct  = 66;
		sink_idle_pct = 34;
		send_mix(460);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		send_mix(670);
		@(negedge clk);
		s_tvalid <= 1'b0;

		// drain, then watch for stray words past the longest latency
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (2 * WORD_BITS) @(posedge clk);
		if (tracker.errors == 0 && tracker.awaited.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

[filelist.f]
rtl/itee_pkg.sv
rtl/itee_alu.sv
rtl/infix_token_expression_evaluator_top.sv
bench/tb_top.sv
